// ----- rtl/prcf_pkg.sv -----
`default_nettype none

package prcf_pkg;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int ROW_OUT_W = 8;

  // threshold = total / (THR_DIV * rows), radius = rows / RAD_DIV
  localparam int THR_DIV = 3;
  localparam int RAD_DIV = 20;

  // radius by reciprocal multiply: (rows * RAD_RECIP) >> RAD_SHIFT,
  // exact for fewer than 16384 rows
  localparam int RAD_SHIFT = 16;
  localparam int RAD_RECIP = ((1 << RAD_SHIFT) + RAD_DIV - 1) / RAD_DIV;

endpackage

`default_nettype wire

// ----- rtl/prcf_ram.sv -----
`default_nettype none

module prcf_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/projection_row_crop_finder_unit.sv -----
`default_nettype none

// Row crop finder by horizontal projection. Gray pixels stream in raster order,
// one item per cycle, with row_end on the last pixel of each row and frame_end on
// the last pixel of the frame (frame_end also closes the row). Each row sum goes
// into a row-sum RAM and a frame total is kept, both saturating. On frame_end the
// input stalls: a restoring divider, one quotient bit per cycle, forms
// threshold = total / (3 * rows) bit by bit over the TW-bit total (TW = 26 at the
// default size), and radius = rows / 20 comes from a reciprocal multiply, taken
// when the divide ends. A sequencer then walks the RAM from the top and then from
// the bottom, each RAM read spanning an address state and a registered-data state:
// each candidate row costs one read, and one below the threshold costs up to one
// read per row of its window of +-max(radius,1) rows, stopping at a smaller row.
// A row qualifies when it is below the threshold and no row in its window is smaller.
// One result item per frame carries both row indices (low 8 bits) and found flags;
// a row not found reports index 0. The caller crops rows top_row+1 .. bottom_row-1.
// Pixels of the next frame are taken again once the result has entered the output
// register, even while it still waits there. Rows past MAX_ROWS are dropped.
module projection_row_crop_finder_unit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [prcf_pkg::PIX_W-1:0]         pixel,
  input  wire logic                               row_end,
  input  wire logic                               frame_end,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [prcf_pkg::ROW_OUT_W-1:0]     top_row,
  output logic                                    top_found,
  output logic      [prcf_pkg::ROW_OUT_W-1:0]     bottom_row,
  output logic                                    bottom_found
);

  import prcf_pkg::*;

  localparam int          ROW_MAX = MAX_COLS * 255;
  localparam int          RW      = $clog2(ROW_MAX + 1);
  localparam logic [63:0] TOT_MAX = 64'(MAX_ROWS) * 64'(MAX_COLS) * 64'd255;
  localparam int          TW      = $clog2(TOT_MAX + 64'd1);
  localparam int          NW      = $clog2(MAX_ROWS + 1);
  localparam int          AW      = $clog2(MAX_ROWS);
  localparam int          DVW     = $clog2(THR_DIV * MAX_ROWS + 1);
  localparam int          CW      = $clog2(TW);
  localparam int          RPW     = NW + $clog2(RAD_RECIP + 1);

  typedef enum logic [2:0] {
    ACCUM, DIV_THR, CAND_RD, CAND_CHK, WIN_RD, WIN_CHK, DONE
  } state_t;

  state_t state;

  // accumulation
  logic [RW-1:0]  rsum;
  logic [TW-1:0]  total;
  logic [NW-1:0]  rows_seen;
  logic [NW-1:0]  frame_rows;

  // divider
  logic [TW-1:0]  div_q;
  logic [DVW-1:0] div_rem;
  logic [DVW-1:0] div_d;
  logic [CW-1:0]  div_cnt;

  // scan
  logic [TW-1:0]  thr;
  logic [AW-1:0]  rad;
  logic           dir;        // 0: from top, 1: from bottom
  logic [AW-1:0]  cand;
  logic [RW-1:0]  cand_v;
  logic [AW-1:0]  win_k;
  logic [AW-1:0]  win_hi;
  logic           tf;
  logic           bf;
  logic [AW-1:0]  top_idx;
  logic [AW-1:0]  bot_idx;

  // RAM
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [RW-1:0]  ram_rdata;

  // accumulate path
  logic           take;
  logic           room;
  logic [RW:0]    rsum_add;
  logic [RW-1:0]  rsum_sat;
  logic [TW:0]    tot_add;
  logic [TW-1:0]  tot_sat;
  logic [TW-1:0]  tot_final;
  logic [NW-1:0]  rows_inc;
  logic [NW-1:0]  rows_final;

  // divider step
  logic [DVW:0]   trial;
  logic           ge;
  logic [DVW-1:0] rem_new;
  logic [TW-1:0]  q_new;

  // radius
  logic [RPW-1:0] rad_prod;
  logic [AW-1:0]  rad_q;

  // window bounds and scan stepping
  logic [AW-1:0]  last_row;
  logic [AW:0]    hi_sum;
  logic [AW-1:0]  win_lo;
  logic [AW-1:0]  win_top;
  logic           last_cand;
  logic [AW-1:0]  cand_step;

  // result load
  logic           out_load;

  assign in_ready = (state == ACCUM);
  assign take     = in_valid && in_ready;
  assign room     = rows_seen < NW'(MAX_ROWS);

  assign rsum_add = {1'b0, rsum} + (RW + 1)'(pixel);
  assign rsum_sat = (rsum_add > (RW + 1)'(ROW_MAX)) ? RW'(ROW_MAX) : rsum_add[RW-1:0];
  assign tot_add  = {1'b0, total} + (TW + 1)'(pixel);
  assign tot_sat  = (tot_add > (TW + 1)'(TOT_MAX)) ? TW'(TOT_MAX) : tot_add[TW-1:0];

  assign tot_final  = room ? tot_sat : total;
  assign rows_inc   = rows_seen + NW'(1);
  assign rows_final = room ? rows_inc : rows_seen;

  // row sums are written only while pixels are taken and read only in the scan,
  // when the input is stalled, so the two never touch the same cycle
  assign ram_we    = take && room && (row_end || frame_end);
  assign ram_raddr = (state == WIN_RD) ? win_k : cand;

  prcf_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ROWS)
  ) u_row_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rows_seen[AW-1:0]),
    .wdata (rsum_sat),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring division, one quotient bit per cycle
  assign trial   = {div_rem, div_q[TW-1]};
  assign ge      = trial >= {1'b0, div_d};
  assign rem_new = ge ? DVW'(trial - {1'b0, div_d}) : trial[DVW-1:0];
  assign q_new   = {div_q[TW-2:0], ge};

  // rows / 20 by reciprocal multiply
  assign rad_prod = RPW'(frame_rows) * RPW'(RAD_RECIP);
  assign rad_q    = AW'(rad_prod >> RAD_SHIFT);

  // window of the candidate, clipped to the frame
  assign last_row  = AW'(frame_rows - NW'(1));
  assign hi_sum    = {1'b0, cand} + {1'b0, rad};
  assign win_lo    = (cand >= rad) ? AW'(cand - rad) : '0;
  assign win_top   = (hi_sum > {1'b0, last_row}) ? last_row : hi_sum[AW-1:0];
  assign last_cand = dir ? (cand == '0) : (cand == last_row);
  assign cand_step = dir ? AW'(cand - AW'(1)) : AW'(cand + AW'(1));

  // result enters the output register once it is free
  assign out_load = (state == DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ACCUM;
      rsum      <= '0;
      total     <= '0;
      rows_seen <= '0;
      out_valid <= 1'b0;
      tf        <= 1'b0;
      bf        <= 1'b0;
      dir       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ACCUM: begin
          if (take) begin
            if (frame_end) begin
              frame_rows <= rows_final;
              rsum       <= '0;
              total      <= '0;
              rows_seen  <= '0;
              tf         <= 1'b0;
              bf         <= 1'b0;
              div_q      <= tot_final;
              div_rem    <= '0;
              div_d      <= DVW'(rows_final) * DVW'(THR_DIV);
              div_cnt    <= '0;
              state      <= DIV_THR;
            end else if (room) begin
              total <= tot_sat;
              if (row_end) begin
                rsum      <= '0;
                rows_seen <= rows_inc;
              end else begin
                rsum <= rsum_sat;
              end
            end
          end
        end

        DIV_THR: begin
          if (div_cnt == CW'(TW - 1)) begin
            thr   <= q_new;
            // direct neighbors are always checked, so the window is at least one
            rad   <= (rad_q == '0) ? AW'(1) : rad_q;
            dir   <= 1'b0;
            cand  <= '0;
            state <= CAND_RD;
          end else begin
            div_q   <= q_new;
            div_rem <= rem_new;
            div_cnt <= div_cnt + CW'(1);
          end
        end

        CAND_RD: begin
          state <= CAND_CHK;
        end

        CAND_CHK: begin
          if (TW'(ram_rdata) < thr) begin
            cand_v <= ram_rdata;
            win_k  <= win_lo;
            win_hi <= win_top;
            state  <= WIN_RD;
          end else if (last_cand) begin
            if (dir) begin
              state <= DONE;
            end else begin
              dir   <= 1'b1;
              cand  <= last_row;
              state <= CAND_RD;
            end
          end else begin
            cand  <= cand_step;
            state <= CAND_RD;
          end
        end

        WIN_RD: begin
          state <= WIN_CHK;
        end

        WIN_CHK: begin
          if (ram_rdata < cand_v) begin
            // not a minimum: next candidate
            if (last_cand) begin
              if (dir) begin
                state <= DONE;
              end else begin
                dir   <= 1'b1;
                cand  <= last_row;
                state <= CAND_RD;
              end
            end else begin
              cand  <= cand_step;
              state <= CAND_RD;
            end
          end else if (win_k == win_hi) begin
            if (dir) begin
              bf      <= 1'b1;
              bot_idx <= cand;
              state   <= DONE;
            end else begin
              tf      <= 1'b1;
              top_idx <= cand;
              dir     <= 1'b1;
              cand    <= last_row;
              state   <= CAND_RD;
            end
          end else begin
            win_k <= AW'(win_k + AW'(1));
            state <= WIN_RD;
          end
        end

        DONE: begin
          // wait for the output register to free up
          if (out_load) begin
            top_found    <= tf;
            bottom_found <= bf;
            top_row      <= tf ? ROW_OUT_W'(top_idx) : '0;
            bottom_row   <= bf ? ROW_OUT_W'(bot_idx) : '0;
            state        <= ACCUM;
          end
        end

        default: begin
          state <= ACCUM;
        end
      endcase
    end
  end

  // frame end stalls the input for the divide and scan
  a_fend_stall: assert property (@(posedge clk) disable iff (rst)
    take && frame_end |=> !in_ready)
    else $error("input not stalled after frame end");

  // a row qualifying from the top also qualifies from the bottom
  a_found_pair: assert property (@(posedge clk) disable iff (rst)
    state == DONE |-> (tf == bf) && (!tf || (top_idx <= bot_idx)))
    else $error("top and bottom results disagree");

  // missing rows report index zero
  a_zero_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !top_found |-> top_row == '0)
    else $error("top_row nonzero without top_found");

  // window walk stays inside the stored rows
  a_win_range: assert property (@(posedge clk) disable iff (rst)
    (state == WIN_RD) |-> (win_k <= win_hi) && (win_hi <= last_row))
    else $error("window index out of range");

  // row count never passes the RAM depth
  a_rows_cap: assert property (@(posedge clk) disable iff (rst)
    rows_seen <= NW'(MAX_ROWS))
    else $error("row count overflow");

endmodule

`default_nettype wire

// ----- test/crop_row_checker.sv -----
module crop_row_checker #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [prcf_pkg::PIX_W-1:0]        pixel,
  input  logic                              row_end,
  input  logic                              frame_end,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [prcf_pkg::ROW_OUT_W-1:0]    top_row,
  input  logic                              top_found,
  input  logic [prcf_pkg::ROW_OUT_W-1:0]    bottom_row,
  input  logic                              bottom_found,
  output int                                errors,
  output int                                results_seen,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned ROW_CAP   = 64'(MAX_COLS) * 255;
  localparam longint unsigned TOTAL_CAP = 64'(MAX_ROWS) * 64'(MAX_COLS) * 255;
  localparam int ROW_W   = $clog2(ROW_CAP + 1);
  localparam int TOTAL_W = $clog2(TOTAL_CAP + 1);

  typedef struct packed {
    logic [prcf_pkg::ROW_OUT_W-1:0] top_row;
    logic                           top_found;
    logic [prcf_pkg::ROW_OUT_W-1:0] bottom_row;
    logic                           bottom_found;
  } crop_rows_t;

  logic [ROW_W-1:0]   row_sum_mem [MAX_ROWS];
  logic [ROW_W-1:0]   cur_row_sum;
  logic [TOTAL_W-1:0] frame_sum;
  int                 rows_stored;
  crop_rows_t         expected_crops [$];
  int                 err_cnt;
  int                 got_cnt;

  // row is a trough: no larger than its direct neighbors, none smaller in its window
  function automatic bit is_trough(int n, int at);
    int radius;
    int lo;
    int hi;
    logic [ROW_W-1:0] v;
    radius = n / prcf_pkg::RAD_DIV;
    v = row_sum_mem[at];
    if (at >= 1 && v > row_sum_mem[at-1]) return 1'b0;
    if (at + 1 < n && v > row_sum_mem[at+1]) return 1'b0;
    lo = (at >= radius) ? at - radius : 0;
    hi = at + radius;
    if (hi > n - 1) hi = n - 1;
    for (int k = lo; k <= hi; k++) begin
      if (row_sum_mem[k] < v) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic crop_rows_t find_crop_rows();
    crop_rows_t r;
    longint unsigned thr;
    int n;
    r = '0;
    n = rows_stored;
    if (n > 0) begin
      thr = 64'(frame_sum) / 64'(prcf_pkg::THR_DIV * n);
      for (int i = 0; i < n; i++) begin
        if (row_sum_mem[i] < thr && is_trough(n, i)) begin
          r.top_row   = 8'(i);
          r.top_found = 1'b1;
          break;
        end
      end
      for (int i = n - 1; i >= 0; i--) begin
        if (row_sum_mem[i] < thr && is_trough(n, i)) begin
          r.bottom_row   = 8'(i);
          r.bottom_found = 1'b1;
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    longint unsigned acc;
    crop_rows_t want;
    crop_rows_t got;
    if (rst) begin
      cur_row_sum = '0;
      frame_sum   = '0;
      rows_stored = 0;
      expected_crops.delete();
      err_cnt = 0;
      got_cnt = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (rows_stored < MAX_ROWS) begin
          acc = 64'(cur_row_sum) + 64'(pixel);
          cur_row_sum = (acc > ROW_CAP) ? ROW_W'(ROW_CAP) : ROW_W'(acc);
          acc = 64'(frame_sum) + 64'(pixel);
          frame_sum = (acc > TOTAL_CAP) ? TOTAL_W'(TOTAL_CAP) : TOTAL_W'(acc);
          if (row_end || frame_end) begin
            row_sum_mem[rows_stored] = cur_row_sum;
            rows_stored++;
            cur_row_sum = '0;
          end
        end
        if (frame_end) begin
          expected_crops.push_back(find_crop_rows());
          cur_row_sum = '0;
          frame_sum   = '0;
          rows_stored = 0;
        end
      end
      if (out_valid && out_ready) begin
        got_cnt++;
        got = '{top_row, top_found, bottom_row, bottom_found};
        if (expected_crops.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected crop item top %0d/%0b bottom %0d/%0b", $time,
                     got.top_row, got.top_found, got.bottom_row, got.bottom_found);
        end else begin
          want = expected_crops.pop_front();
          if (got != want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: crop mismatch, want %0d/%0b %0d/%0b, got %0d/%0b %0d/%0b",
                       $time, want.top_row, want.top_found, want.bottom_row,
                       want.bottom_found, got.top_row, got.top_found, got.bottom_row,
                       got.bottom_found);
          end
        end
      end
    end
    errors       <= err_cnt;
    results_seen <= got_cnt;
    pending      <= expected_crops.size();
  end

endmodule

// ----- test/projection_row_crop_finder_unit_test.sv -----
module projection_row_crop_finder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 1024;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // sender side, known from time zero
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [prcf_pkg::PIX_W-1:0]        pixel     = '0;
  logic                              row_end   = 1'b0;
  logic                              frame_end = 1'b0;

  // receiver side
  logic                              out_valid;
  logic                              out_ready = 1'b1;
  logic [prcf_pkg::ROW_OUT_W-1:0]    top_row;
  logic                              top_found;
  logic [prcf_pkg::ROW_OUT_W-1:0]    bottom_row;
  logic                              bottom_found;

  int errors;
  int results_seen;
  int pending;

  // idle / stall odds in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;

  int items_sent  = 0;
  int frames_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  projection_row_crop_finder_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .top_row      (top_row),
    .top_found    (top_found),
    .bottom_row   (bottom_row),
    .bottom_found (bottom_found)
  );

  crop_row_checker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .top_row      (top_row),
    .top_found    (top_found),
    .bottom_row   (bottom_row),
    .bottom_found (bottom_found),
    .errors       (errors),
    .results_seen (results_seen),
    .pending      (pending)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // One item: random idle cycles first (valid low), then hold valid with a
  // steady payload until accepted. Valid is left high on return, so a
  // following item keeps it up without a low/high pair in one step.
  task automatic send_item(input logic [prcf_pkg::PIX_W-1:0] px, input logic re,
                           input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel     <= px;
    row_end   <= re;
    frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (fe) frames_sent++;
  endtask

  // row of equal pixels; 'last' closes the frame on its final pixel
  task automatic send_flat_row(input int cols, input logic [prcf_pkg::PIX_W-1:0] val,
                               input bit last);
    for (int c = 0; c < cols; c++)
      send_item(val, c == cols - 1, last && (c == cols - 1));
  endtask

  // stop sending and wait for every frame's crop item
  task automatic drain_crops();
    in_valid <= 1'b0;
    while (results_seen < frames_sent) @(posedge clk);
  endtask

  // Random frame. Mostly small frames with bright rows and a few dark bands,
  // so that troughs exist; some flat and pure-noise frames; ragged row widths;
  // now and then a frame of medium height (radius > 0) or one past MAX_ROWS.
  task automatic send_random_frame();
    int pick;
    int nrows;
    int ncols;
    int cols;
    int kind;
    int lvl;
    bit ragged;
    bit close_row;
    bit dark;
    bit last_px;
    logic [prcf_pkg::PIX_W-1:0] px;
    logic re;
    logic fe;
    pick = $urandom_range(39);
    if (pick == 0) begin
      nrows = $urandom_range(240, 270);
      ncols = 1;
    end else if (pick < 7) begin
      nrows = $urandom_range(20, 70);
      ncols = $urandom_range(1, 3);
    end else begin
      nrows = $urandom_range(1, 24);
      ncols = $urandom_range(1, 6);
    end
    kind      = $urandom_range(9);
    lvl       = $urandom_range(255);
    ragged    = ($urandom_range(3) == 0);
    close_row = $urandom_range(1);
    for (int r = 0; r < nrows; r++) begin
      cols = ragged ? $urandom_range(1, 2 * ncols) : ncols;
      dark = ($urandom_range(4) == 0);
      for (int c = 0; c < cols; c++) begin
        last_px = (c == cols - 1);
        fe = last_px && (r == nrows - 1);
        // frame end sometimes arrives without its row end
        re = last_px && (!fe || close_row);
        case (kind)
          0:       px = 8'(lvl);
          1, 2:    px = 8'($urandom_range(255));
          default: px = dark ? 8'($urandom_range(40)) : 8'($urandom_range(120, 255));
        endcase
        send_item(px, re, fe);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed frames, no idling ---
    // one-pixel frames: frame end alone, then with row end
    send_item(8'd0, 1'b0, 1'b1);
    send_item(8'd255, 1'b1, 1'b1);

    // two dark rows between bright ones: top and bottom differ
    send_flat_row(3, 8'd200, 0);
    send_flat_row(3, 8'd10, 0);
    send_flat_row(3, 8'd200, 0);
    send_flat_row(3, 8'd10, 0);
    send_flat_row(3, 8'd200, 1);

    // all-zero frame: threshold 0, nothing qualifies
    for (int r = 0; r < 4; r++) send_flat_row(4, 8'd0, r == 3);

    // 40 rows, radius 2: a plateau of equal minima, a dip beaten by a
    // deeper one inside its window, and a minimum on the bottom edge
    for (int r = 0; r < 40; r++) begin
      case (r)
        7, 8:    send_flat_row(1, 8'd5, 0);
        20:      send_flat_row(1, 8'd30, 0);
        22:      send_flat_row(1, 8'd20, 0);
        39:      send_flat_row(1, 8'd0, 1);
        default: send_flat_row(1, 8'd200, 0);
      endcase
    end

    // more than MAX_ROWS rows: rows past the limit are dropped, frame end
    // still closes the frame
    for (int r = 0; r < 300; r++)
      send_flat_row(1, (r % 37 == 5) ? 8'd3 : 8'd250, r == 299);

    // multi-pixel frame ending without a row end
    send_flat_row(4, 8'd100, 0);
    send_flat_row(4, 8'd100, 0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h0F, 1'b0, 1'b1);

    drain_crops();

    // --- random frames over idle/stall phases; sender waits for all crop
    //     items between phases ---
    for (int ph = 0; ph < 4; ph++) begin : phases
      int item_mark;
      int frame_mark;
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      item_mark  = items_sent;
      frame_mark = frames_sent;
      while (items_sent - item_mark < 300 || frames_sent - frame_mark < 16)
        send_random_frame();
      drain_crops();
    end

    // tail: catch any stray output
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("projection_row_crop_finder_unit_test: done, clean");
    else
      $display("projection_row_crop_finder_unit_test: done, errors");
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin
    #30_000_000;
    $display("projection_row_crop_finder_unit_test: done, errors");
    $finish;
  end

endmodule
